// ===== sv/urbe_pkg.sv =====
// Package for the UART ring buffer engine: ring depths, address widths,
// request codes and the ring pointer helper functions. No dependencies.
`default_nettype none

package urbe_pkg;

    localparam int TX_DEPTH = 64;
    localparam int RX_DEPTH = 64;
    localparam int TX_AW    = $clog2(TX_DEPTH);
    localparam int RX_AW    = $clog2(RX_DEPTH);

    localparam int FUNC_W   = 3;
    localparam int DATA_W   = 8;
    localparam int AMT_W    = 6;
    localparam int WAIT_W   = 6;
    localparam int WAIT_MAX = (1 << WAIT_W) - 1;

    // Width wide enough to compare a request amount against a ring count.
    localparam int RX_CW = ((RX_AW > AMT_W) ? RX_AW : AMT_W) + 1;

    localparam logic [FUNC_W-1:0] FUNC_TX_ENQ  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_TX_DONE = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_RX_BYTE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ    = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_SKIP    = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_BLOCK   = 3'd5;

    function automatic logic [TX_AW-1:0] tx_inc(input logic [TX_AW-1:0] i);
        return (i == TX_AW'(TX_DEPTH - 1)) ? '0 : i + TX_AW'(1);
    endfunction

    function automatic logic [RX_AW-1:0] rx_inc(input logic [RX_AW-1:0] i);
        return (i == RX_AW'(RX_DEPTH - 1)) ? '0 : i + RX_AW'(1);
    endfunction

    // Both operands are below the depth, so one conditional subtract wraps the sum.
    function automatic logic [RX_AW-1:0] rx_add(input logic [RX_AW-1:0] base,
                                                input logic [RX_AW-1:0] n);
        logic [RX_AW:0] sum;
        sum = {1'b0, base} + {1'b0, n};
        if (sum >= (RX_AW + 1)'(RX_DEPTH)) begin
            sum = sum - (RX_AW + 1)'(RX_DEPTH);
        end
        return sum[RX_AW-1:0];
    endfunction

    // The tail sits one slot behind the first waiting byte.
    function automatic logic [RX_AW-1:0] rx_count(input logic [RX_AW-1:0] h,
                                                  input logic [RX_AW-1:0] t);
        logic [RX_AW:0] d;
        if (h > t) begin
            d = {1'b0, h} - {1'b0, t} - (RX_AW + 1)'(1);
        end else begin
            d = {1'b0, h} + (RX_AW + 1)'(RX_DEPTH) - {1'b0, t} - (RX_AW + 1)'(1);
        end
        return d[RX_AW-1:0];
    endfunction

    function automatic logic [WAIT_W-1:0] wait_sat(input logic [RX_AW-1:0] c);
        logic [RX_CW-1:0] cw;
        cw = RX_CW'(c);
        return (cw > RX_CW'(WAIT_MAX)) ? WAIT_W'(WAIT_MAX) : cw[WAIT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/uart_ring_buffer_engine.sv =====
// Top level of the UART ring buffer engine: request sequencer, ring pointers
// and result register. Uses urbe_pkg and two instances of urbe_ram.
`default_nettype none

// A transmit ring and a receive ring for one UART, both held in RAMs with a
// registered read port. One request is handled at a time. A request that
// needs no ring read (enqueue, received byte, skip, transmit done with
// nothing pending, out-of-range read, empty block) goes from IDLE straight
// to OUT, where its result is shown, after which s_ready returns once the
// result is taken. A request that reads a ring (transmit done with a byte
// pending, read at offset) passes through READ before OUT because of the RAM
// read latency. A block read of n bytes gives n results; each taken result
// but the last sends the sequencer back through READ for the next byte, as
// every byte is a separate RAM read. An enqueued byte that meets an idle
// transmitter is handed out directly from the request, without a RAM read.
// The ring contents need no clearing after reset: only written entries are ever read.
module uart_ring_buffer_engine (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [2:0] s_func,
    input  wire logic [7:0] s_data,
    input  wire logic [5:0] s_amount,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_tx_valid,
    output logic      [7:0] m_tx_byte,
    output logic      [7:0] m_read_data,
    output logic            m_read_valid,
    output logic      [5:0] m_rx_waiting,
    output logic            m_tx_busy,
    output logic            m_rx_dropped,
    output logic            m_tx_overflow,
    output logic            m_last
);

    localparam int TX_AW  = urbe_pkg::TX_AW;
    localparam int RX_AW  = urbe_pkg::RX_AW;
    localparam int DW     = urbe_pkg::DATA_W;
    localparam int WW     = urbe_pkg::WAIT_W;
    localparam int RX_CW  = urbe_pkg::RX_CW;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [TX_AW-1:0] tx_head_reg, tx_head_next;
    logic [TX_AW-1:0] tx_tail_reg, tx_tail_next;
    logic             tx_run_reg, tx_run_next;
    logic [RX_AW-1:0] rx_head_reg, rx_head_next;
    logic [RX_AW-1:0] rx_tail_reg, rx_tail_next;
    logic [RX_AW-1:0] ptr_reg, ptr_next;
    logic [RX_AW-1:0] left_reg, left_next;
    logic             src_tx_reg, src_tx_next;

    logic             out_tx_valid_reg, out_tx_valid_next;
    logic [DW-1:0]    out_tx_byte_reg, out_tx_byte_next;
    logic [DW-1:0]    out_read_data_reg, out_read_data_next;
    logic             out_read_valid_reg, out_read_valid_next;
    logic [WW-1:0]    out_waiting_reg, out_waiting_next;
    logic             out_busy_reg, out_busy_next;
    logic             out_dropped_reg, out_dropped_next;
    logic             out_overflow_reg, out_overflow_next;
    logic             out_last_reg, out_last_next;

    logic             tx_we, rx_we;
    logic [TX_AW-1:0] tx_waddr, tx_raddr;
    logic [RX_AW-1:0] rx_waddr, rx_raddr;
    logic [DW-1:0]    tx_rdata, rx_rdata;

    logic [RX_AW-1:0] rx_cnt;
    logic             amt_lt;
    logic [RX_AW-1:0] take_n;

    urbe_ram #(.WIDTH(DW), .DEPTH(urbe_pkg::TX_DEPTH)) u_tx_ram (
        .aclk  (aclk),
        .we    (tx_we),
        .waddr (tx_waddr),
        .wdata (s_data),
        .raddr (tx_raddr),
        .rdata (tx_rdata)
    );

    urbe_ram #(.WIDTH(DW), .DEPTH(urbe_pkg::RX_DEPTH)) u_rx_ram (
        .aclk  (aclk),
        .we    (rx_we),
        .waddr (rx_waddr),
        .wdata (s_data),
        .raddr (rx_raddr),
        .rdata (rx_rdata)
    );

    assign rx_cnt = urbe_pkg::rx_count(rx_head_reg, rx_tail_reg);
    assign amt_lt = RX_CW'(s_amount) < RX_CW'(rx_cnt);
    assign take_n = amt_lt ? RX_AW'(s_amount) : rx_cnt;

    assign tx_waddr = tx_head_reg;
    assign rx_waddr = rx_head_reg;
    assign tx_raddr = tx_tail_reg;
    // IDLE reads a read's offset byte or a block's first byte; then it walks a block.
    assign rx_raddr = (state_reg == S_IDLE)
                    ? urbe_pkg::rx_add(urbe_pkg::rx_inc(rx_tail_reg),
                                       (s_func == urbe_pkg::FUNC_READ) ? take_n : '0)
                    : urbe_pkg::rx_inc(ptr_reg);

    always_comb begin
        state_next          = state_reg;
        tx_head_next        = tx_head_reg;
        tx_tail_next        = tx_tail_reg;
        tx_run_next         = tx_run_reg;
        rx_head_next        = rx_head_reg;
        rx_tail_next        = rx_tail_reg;
        ptr_next            = ptr_reg;
        left_next           = left_reg;
        src_tx_next         = src_tx_reg;
        out_tx_valid_next   = out_tx_valid_reg;
        out_tx_byte_next    = out_tx_byte_reg;
        out_read_data_next  = out_read_data_reg;
        out_read_valid_next = out_read_valid_reg;
        out_waiting_next    = out_waiting_reg;
        out_busy_next       = out_busy_reg;
        out_dropped_next    = out_dropped_reg;
        out_overflow_next   = out_overflow_reg;
        out_last_next       = out_last_reg;
        tx_we               = 1'b0;
        rx_we               = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    out_tx_valid_next   = 1'b0;
                    out_tx_byte_next    = '0;
                    out_read_data_next  = '0;
                    out_read_valid_next = 1'b0;
                    out_dropped_next    = 1'b0;
                    out_overflow_next   = 1'b0;
                    out_last_next       = 1'b1;
                    src_tx_next         = 1'b0;
                    left_next           = '0;
                    state_next          = S_OUT;
                    unique case (s_func)
                        urbe_pkg::FUNC_TX_ENQ: begin
                            if (urbe_pkg::tx_inc(tx_head_reg) == tx_tail_reg) begin
                                out_overflow_next = 1'b1;
                            end else begin
                                tx_we        = 1'b1;
                                tx_head_next = urbe_pkg::tx_inc(tx_head_reg);
                                // An idle transmitter has an empty ring, so the
                                // byte at the tail is the one being written.
                                if (!tx_run_reg) begin
                                    tx_run_next       = 1'b1;
                                    tx_tail_next      = urbe_pkg::tx_inc(tx_tail_reg);
                                    out_tx_valid_next = 1'b1;
                                    out_tx_byte_next  = s_data;
                                end
                            end
                        end
                        urbe_pkg::FUNC_TX_DONE: begin
                            if (tx_tail_reg != tx_head_reg) begin
                                tx_tail_next      = urbe_pkg::tx_inc(tx_tail_reg);
                                out_tx_valid_next = 1'b1;
                                src_tx_next       = 1'b1;
                                state_next        = S_READ;
                            end else begin
                                tx_run_next = 1'b0;
                            end
                        end
                        urbe_pkg::FUNC_RX_BYTE: begin
                            if (rx_tail_reg != rx_head_reg) begin
                                rx_we        = 1'b1;
                                rx_head_next = urbe_pkg::rx_inc(rx_head_reg);
                            end else begin
                                out_dropped_next = 1'b1;
                            end
                        end
                        urbe_pkg::FUNC_READ: begin
                            if (amt_lt) begin
                                out_read_valid_next = 1'b1;
                                state_next          = S_READ;
                            end
                        end
                        urbe_pkg::FUNC_SKIP: begin
                            rx_tail_next = urbe_pkg::rx_add(rx_tail_reg, take_n);
                        end
                        urbe_pkg::FUNC_BLOCK: begin
                            rx_tail_next = urbe_pkg::rx_add(rx_tail_reg, take_n);
                            if (take_n != '0) begin
                                out_read_valid_next = 1'b1;
                                ptr_next            = urbe_pkg::rx_inc(rx_tail_reg);
                                left_next           = take_n - RX_AW'(1);
                                out_last_next       = (take_n == RX_AW'(1));
                                state_next          = S_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                    out_waiting_next = urbe_pkg::wait_sat(
                        urbe_pkg::rx_count(rx_head_next, rx_tail_next));
                    out_busy_next    = tx_run_next;
                end
            end
            S_READ: begin
                if (src_tx_reg) begin
                    out_tx_byte_next = tx_rdata;
                end else begin
                    out_read_data_next = rx_rdata;
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_ready) begin
                    if (left_reg != '0) begin
                        left_next     = left_reg - RX_AW'(1);
                        ptr_next      = urbe_pkg::rx_inc(ptr_reg);
                        out_last_next = (left_reg == RX_AW'(1));
                        state_next    = S_READ;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            tx_head_reg <= '0;
            tx_tail_reg <= '0;
            tx_run_reg  <= 1'b0;
            rx_head_reg <= '0;
            rx_tail_reg <= RX_AW'(urbe_pkg::RX_DEPTH - 1);
            left_reg    <= '0;
            src_tx_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tx_head_reg <= tx_head_next;
            tx_tail_reg <= tx_tail_next;
            tx_run_reg  <= tx_run_next;
            rx_head_reg <= rx_head_next;
            rx_tail_reg <= rx_tail_next;
            left_reg    <= left_next;
            src_tx_reg  <= src_tx_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg            <= ptr_next;
        out_tx_valid_reg   <= out_tx_valid_next;
        out_tx_byte_reg    <= out_tx_byte_next;
        out_read_data_reg  <= out_read_data_next;
        out_read_valid_reg <= out_read_valid_next;
        out_waiting_reg    <= out_waiting_next;
        out_busy_reg       <= out_busy_next;
        out_dropped_reg    <= out_dropped_next;
        out_overflow_reg   <= out_overflow_next;
        out_last_reg       <= out_last_next;
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = (state_reg == S_OUT);
    assign m_tx_valid    = out_tx_valid_reg;
    assign m_tx_byte     = out_tx_byte_reg;
    assign m_read_data   = out_read_data_reg;
    assign m_read_valid  = out_read_valid_reg;
    assign m_rx_waiting  = out_waiting_reg;
    assign m_tx_busy     = out_busy_reg;
    assign m_rx_dropped  = out_dropped_reg;
    assign m_tx_overflow = out_overflow_reg;
    assign m_last        = out_last_reg;

`ifndef NO_ASSERTIONS
    // An idle transmitter must have an empty ring, or the enqueue bypass is wrong.
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !tx_run_reg |-> (tx_head_reg == tx_tail_reg))
        else $error("transmitter idle with bytes pending");

    // Only a block read gives more than one result, and each of those carries a byte.
    a_multi_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> m_read_valid)
        else $error("non-final result without a read byte");

    a_tx_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_tx_valid) |-> m_tx_busy)
        else $error("byte handed out while transmitter idle");

    // No new request is taken until the last result of the current one leaves.
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> !s_ready)
        else $error("request accepted in the middle of a block read");
`endif

endmodule

`default_nettype wire

// ===== sv/urbe_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module urbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
